// ===== rtl/swhsr_pkg.sv =====
// ---------------------------------------------------------------------------
// swhsr_pkg
// Shared types, codes and constants for the single-wire humidity sensor
// reader: channel words, configuration set, read phases and status codes.
// ---------------------------------------------------------------------------
package swhsr_pkg;

   // Frame layout
   localparam int DATA_BITS     = 40;
   localparam int BIT_IDX_W     = 6;
   localparam int TICK_W        = 16;
   localparam int LIMIT_W       = 10;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;

   // Line release time after the start pulse
   localparam logic [TICK_W-1:0] RELEASE_TICKS = 16'd30;

   // Request kinds
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_START = 1'b1;

   // Sensor types
   localparam logic SENSOR_OLD = 1'b0;
   localparam logic SENSOR_NEW = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_TYPE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LOW_SHORT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LOW_LONG   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RESPONSE_TIMEOUT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_LOW_TIMEOUT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_HIGH_TIMEOUT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_THRESHOLD    = 3'd6;

   // Read phases
   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_START_LOW  = 3'd1,
      PH_RELEASE    = 3'd2,
      PH_RESP_HIGH1 = 3'd3,
      PH_RESP_LOW   = 3'd4,
      PH_RESP_HIGH2 = 3'd5,
      PH_BIT_LOW    = 3'd6,
      PH_BIT_HIGH   = 3'd7
   } phase_type;

   // Read completion status
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TIMEOUT  = 2'd1,
      STATUS_CHECKSUM = 2'd2
   } status_type;

   // Input word
   typedef struct packed {
      logic kind;
      logic line_level;
   } req_type;

   // Result word
   typedef struct packed {
      logic                drive_low;
      logic                busy_res;
      logic                done_res;
      status_type          status;
      logic [15:0]         humidity_tenths;
      logic signed [15:0]  temperature_tenths;
   } rsp_type;

   // Configuration set
   typedef struct packed {
      logic                sensor_type;
      logic [TICK_W-1:0]   start_low_short;
      logic [TICK_W-1:0]   start_low_long;
      logic [LIMIT_W-1:0]  response_timeout;
      logic [LIMIT_W-1:0]  bit_low_timeout;
      logic [LIMIT_W-1:0]  bit_high_timeout;
      logic [LIMIT_W-1:0]  one_threshold;
   } cfg_type;

   // Timeout limit of a wait phase
   function automatic logic [LIMIT_W-1:0] phase_limit(phase_type ph, cfg_type cfg);
      logic [LIMIT_W-1:0] lim;
      case (ph)
         PH_BIT_LOW:  lim = cfg.bit_low_timeout;
         PH_BIT_HIGH: lim = cfg.bit_high_timeout;
         default:     lim = cfg.response_timeout;
      endcase
      return lim;
   endfunction

   // Line level a wait phase counts
   function automatic logic phase_level(phase_type ph);
      return !((ph == PH_RESP_LOW) || (ph == PH_BIT_LOW));
   endfunction

endpackage

// ===== rtl/swhsr_frame_dec.sv =====
// ---------------------------------------------------------------------------
// swhsr_frame_dec
// Checks the 40-bit frame checksum and converts the raw bytes into
// humidity and temperature in tenths for either sensor type.
// ---------------------------------------------------------------------------
module swhsr_frame_dec (
   input  logic [swhsr_pkg::DATA_BITS-1:0] frame,
   input  logic                            sensor_type,
   output logic                            cks_ok,
   output logic [15:0]                     humidity,
   output logic [15:0]                     temperature
);
   import swhsr_pkg::*;

   logic [7:0]  b0, b1, b2, b3, b4;
   logic [7:0]  sum8;
   logic [15:0] raw_t;
   logic [15:0] neg_mag;

   // Byte split, first byte received is most significant
   assign b0 = frame[39:32];
   assign b1 = frame[31:24];
   assign b2 = frame[23:16];
   assign b3 = frame[15:8];
   assign b4 = frame[7:0];

   // 8-bit sum checksum
   assign sum8   = b0 + b1 + b2 + b3;
   assign cks_ok = (sum8 == b4);

   // Newer type: sign-magnitude temperature, negative zero folds to 0
   assign raw_t   = {b2, b3};
   assign neg_mag = 16'd0 - {1'b0, raw_t[14:0]};

   always_comb begin
      if (sensor_type == SENSOR_OLD) begin
         // integer value times ten as x*8 + x*2
         humidity    = {5'd0, b0, 3'd0} + {7'd0, b0, 1'b0};
         temperature = {5'd0, b2, 3'd0} + {7'd0, b2, 1'b0};
      end else begin
         humidity    = {b0, b1};
         temperature = raw_t[15] ? neg_mag : raw_t;
      end
   end

endmodule

// ===== rtl/swhsr_seq.sv =====
// ---------------------------------------------------------------------------
// swhsr_seq
// Read sequencer: start pulse, release, three response waits and 40 timed
// data bits. Advances one step per accepted word and forms the result word.
// ---------------------------------------------------------------------------
module swhsr_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  swhsr_pkg::req_type req,
   input  swhsr_pkg::cfg_type cfg,
   output swhsr_pkg::rsp_type rsp
);
   import swhsr_pkg::*;

   phase_type                phase_ff, phase_in;
   logic [TICK_W-1:0]        tick_ff, tick_in;
   logic [BIT_IDX_W-1:0]     bit_idx_ff, bit_idx_in;
   logic [DATA_BITS-1:0]     frame_ff, frame_in;
   logic [15:0]              hum_ff, hum_in;
   logic [15:0]              temp_ff, temp_in;

   logic [TICK_W-1:0]        tick_inc;
   logic [TICK_W-1:0]        start_len;
   logic [LIMIT_W-1:0]       limit_now;
   logic [LIMIT_W-1:0]       limit_next;
   logic                     bit_val;
   logic [DATA_BITS-1:0]     frame_shifted;
   logic [BIT_IDX_W-1:0]     bit_idx_inc;
   phase_type                phase_after;
   logic                     cks_ok;
   logic [15:0]              dec_hum;
   logic [15:0]              dec_temp;
   logic                     done;
   status_type               status;

   // Shared step values
   assign tick_inc      = tick_ff + 16'd1;
   assign start_len     = cfg.sensor_type ? cfg.start_low_short : cfg.start_low_long;
   assign limit_now     = phase_limit(phase_ff, cfg);
   assign bit_val       = (tick_ff > {6'd0, cfg.one_threshold});
   assign frame_shifted = {frame_ff[DATA_BITS-2:0], bit_val};
   assign bit_idx_inc   = bit_idx_ff + 6'd1;

   // Phase entered when the current wait ends on a level change
   always_comb begin
      case (phase_ff)
         PH_RESP_HIGH1: phase_after = PH_RESP_LOW;
         PH_RESP_LOW:   phase_after = PH_RESP_HIGH2;
         PH_BIT_LOW:    phase_after = PH_BIT_HIGH;
         default:       phase_after = PH_BIT_LOW;
      endcase
   end
   assign limit_next = phase_limit(phase_after, cfg);

   swhsr_frame_dec u_frame_dec (
      .frame       (frame_shifted),
      .sensor_type (cfg.sensor_type),
      .cks_ok      (cks_ok),
      .humidity    (dec_hum),
      .temperature (dec_temp)
   );

   // Next state
   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_idx_in = bit_idx_ff;
      frame_in   = frame_ff;
      hum_in     = hum_ff;
      temp_in    = temp_ff;
      done       = 1'b0;
      status     = STATUS_OK;
      if (accept) begin
         if (req.kind == KIND_START) begin
            // start is ignored while a read runs
            if (phase_ff == PH_IDLE) begin
               phase_in   = PH_START_LOW;
               tick_in    = '0;
               bit_idx_in = '0;
               frame_in   = '0;
               hum_in     = '0;
               temp_in    = '0;
            end
         end else begin
            case (phase_ff)
               PH_IDLE: begin
               end
               PH_START_LOW: begin
                  tick_in = tick_inc;
                  if (tick_inc >= start_len) begin
                     phase_in = PH_RELEASE;
                     tick_in  = '0;
                  end
               end
               PH_RELEASE: begin
                  tick_in = tick_inc;
                  if (tick_inc >= RELEASE_TICKS) begin
                     phase_in = PH_RESP_HIGH1;
                     tick_in  = '0;
                  end
               end
               default: begin
                  // wait phases
                  if (req.line_level == phase_level(phase_ff)) begin
                     tick_in = tick_inc;
                     if (tick_inc >= {6'd0, limit_now}) begin
                        done   = 1'b1;
                        status = STATUS_TIMEOUT;
                     end
                  end else begin
                     if (phase_ff == PH_BIT_HIGH) begin
                        frame_in   = frame_shifted;
                        bit_idx_in = bit_idx_inc;
                     end
                     if ((phase_ff == PH_BIT_HIGH) && (bit_idx_inc >= BIT_IDX_W'(DATA_BITS))) begin
                        done = 1'b1;
                        if (cks_ok) begin
                           status  = STATUS_OK;
                           hum_in  = dec_hum;
                           temp_in = dec_temp;
                        end else begin
                           status = STATUS_CHECKSUM;
                        end
                     end else begin
                        // the changed sample opens the next wait as its first tick
                        phase_in = phase_after;
                        tick_in  = 16'd1;
                        if (limit_next <= 10'd1) begin
                           done   = 1'b1;
                           status = STATUS_TIMEOUT;
                        end
                     end
                  end
                  if (done) begin
                     phase_in = PH_IDLE;
                     tick_in  = '0;
                  end
               end
            endcase
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tick_ff    <= '0;
         bit_idx_ff <= '0;
         frame_ff   <= '0;
         hum_ff     <= '0;
         temp_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bit_idx_ff <= bit_idx_in;
         frame_ff   <= frame_in;
         hum_ff     <= hum_in;
         temp_ff    <= temp_in;
      end
   end

   // Result word for this step
   always_comb begin
      rsp.drive_low          = (phase_in == PH_START_LOW);
      rsp.busy_res           = (phase_in != PH_IDLE);
      rsp.done_res           = done;
      rsp.status             = status;
      rsp.humidity_tenths    = hum_in;
      rsp.temperature_tenths = temp_in;
   end

endmodule

// ===== rtl/single_wire_humidity_sensor_reader.sv =====
// ---------------------------------------------------------------------------
// single_wire_humidity_sensor_reader
// Runs one read of a single-wire temperature and humidity sensor, driven
// one microsecond tick per input word.
// ---------------------------------------------------------------------------
// Each input word is one timing tick carrying the sampled line level, or a
// start request. The block takes one word per clock and returns one result
// word per input word, in the next cycle from the output register; the only
// limit on rate is the output handshake, since the sequencer steps once per
// accepted word. drive_low tells the pad to pull the line low; done_res marks
// the word on which a read ends, with status and the values in tenths. The user
// writes configuration registers by index on the csr_ port while idle; not enforced.
// ---------------------------------------------------------------------------
module single_wire_humidity_sensor_reader (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  swhsr_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output swhsr_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [swhsr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [swhsr_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import swhsr_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_word_ff, rsp_word_in;
   rsp_type  seq_rsp;
   logic     accept;

   // Input taken whenever the output register is empty or draining
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   swhsr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg_ff),
      .rsp    (seq_rsp)
   );

   // Configuration register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SENSOR_TYPE:      cfg_in.sensor_type      = csr_wr_data[0];
            CSR_START_LOW_SHORT:  cfg_in.start_low_short  = csr_wr_data;
            CSR_START_LOW_LONG:   cfg_in.start_low_long   = csr_wr_data;
            CSR_RESPONSE_TIMEOUT: cfg_in.response_timeout = csr_wr_data[LIMIT_W-1:0];
            CSR_BIT_LOW_TIMEOUT:  cfg_in.bit_low_timeout  = csr_wr_data[LIMIT_W-1:0];
            CSR_BIT_HIGH_TIMEOUT: cfg_in.bit_high_timeout = csr_wr_data[LIMIT_W-1:0];
            CSR_ONE_THRESHOLD:    cfg_in.one_threshold    = csr_wr_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_type      <= SENSOR_NEW;
         cfg_ff.start_low_short  <= 16'd1500;
         cfg_ff.start_low_long   <= 16'd18000;
         cfg_ff.response_timeout <= 10'd200;
         cfg_ff.bit_low_timeout  <= 10'd100;
         cfg_ff.bit_high_timeout <= 10'd120;
         cfg_ff.one_threshold    <= 10'd40;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Output register
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   assign rsp_word_in  = accept ? seq_rsp : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

// ===== bench/single_wire_humidity_sensor_reader_test.sv =====
// ---------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_test
// Self-checking bench for the single-wire humidity sensor reader. Sensor
// traffic is built from frame bytes and pulse timings, and a cycle-level
// model of the read sequencer predicts every result word. Both channels
// idle and stall at random while results are compared field by field.
// ---------------------------------------------------------------------------
module single_wire_humidity_sensor_reader_test;
   timeunit 1ns;
   timeprecision 1ps;
   import swhsr_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   single_wire_humidity_sensor_reader u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Sequencer model state and its copy of the registers
   cfg_type     reg_set;
   phase_type   rd_phase = PH_IDLE;
   logic [15:0] rd_ticks = '0;
   logic [5:0]  rd_bits = '0;
   logic [39:0] rd_frame = '0;
   logic [15:0] rd_hum = '0;
   logic [15:0] rd_temp = '0;

   rsp_type     reader_outputs_due[$];
   int unsigned ticks_sent = 0;
   int unsigned fail_count = 0;
   int          send_gap_pct = 0;
   int          recv_stall_pct = 0;

   // Timeout limit of the current wait
   function automatic logic [9:0] wait_limit(phase_type ph);
      case (ph)
         PH_BIT_LOW:  return reg_set.bit_low_timeout;
         PH_BIT_HIGH: return reg_set.bit_high_timeout;
         default:     return reg_set.response_timeout;
      endcase
   endfunction

   // Checksum and scaling of a complete frame
   task automatic close_frame(output status_type st);
      logic [7:0]  sum8;
      logic [15:0] raw;
      sum8 = rd_frame[39:32] + rd_frame[31:24] + rd_frame[23:16] + rd_frame[15:8];
      raw  = rd_frame[23:8];
      if (sum8 != rd_frame[7:0]) begin
         st = STATUS_CHECKSUM;
      end else begin
         st = STATUS_OK;
         if (reg_set.sensor_type == SENSOR_OLD) begin
            rd_hum  = {8'd0, rd_frame[39:32]} * 16'd10;
            rd_temp = {8'd0, rd_frame[23:16]} * 16'd10;
         end else begin
            rd_hum  = rd_frame[39:24];
            rd_temp = raw[15] ? 16'd0 - {1'b0, raw[14:0]} : raw;
         end
      end
   endtask

   // One tick of a level wait; a level change hands the sample to the next wait
   task automatic wait_step(input logic line, output logic fin, output status_type st);
      logic lvl;
      fin = 1'b0;
      st  = STATUS_OK;
      repeat (2) begin
         lvl = !((rd_phase == PH_RESP_LOW) || (rd_phase == PH_BIT_LOW));
         if (line == lvl) begin
            rd_ticks = rd_ticks + 16'd1;
            if (rd_ticks >= wait_limit(rd_phase)) begin
               fin = 1'b1;
               st  = STATUS_TIMEOUT;
            end
            return;
         end
         if (rd_phase == PH_BIT_HIGH) begin
            rd_frame = {rd_frame[38:0], (rd_ticks > reg_set.one_threshold)};
            rd_bits  = rd_bits + 6'd1;
            if (rd_bits >= DATA_BITS) begin
               fin = 1'b1;
               close_frame(st);
               return;
            end
            rd_phase = PH_BIT_LOW;
         end else begin
            rd_phase = phase_type'(rd_phase + 3'd1);
         end
         rd_ticks = '0;
      end
   endtask

   // Advance the model by one accepted word and form the result it gives
   task automatic step_reader(input req_type w, output rsp_type r);
      logic        fin;
      status_type  st;
      logic [15:0] pulse_len;
      fin = 1'b0;
      st  = STATUS_OK;
      pulse_len = (reg_set.sensor_type == SENSOR_NEW) ? reg_set.start_low_short
                                                      : reg_set.start_low_long;
      if (w.kind == KIND_START) begin
         // start while busy is dropped
         if (rd_phase == PH_IDLE) begin
            rd_phase = PH_START_LOW;
            rd_ticks = '0;
            rd_bits  = '0;
            rd_frame = '0;
            rd_hum   = '0;
            rd_temp  = '0;
         end
      end else begin
         case (rd_phase)
            PH_IDLE: ;
            PH_START_LOW: begin
               rd_ticks = rd_ticks + 16'd1;
               if (rd_ticks >= pulse_len) begin
                  rd_phase = PH_RELEASE;
                  rd_ticks = '0;
               end
            end
            PH_RELEASE: begin
               rd_ticks = rd_ticks + 16'd1;
               if (rd_ticks >= RELEASE_TICKS) begin
                  rd_phase = PH_RESP_HIGH1;
                  rd_ticks = '0;
               end
            end
            default: begin
               wait_step(w.line_level, fin, st);
               if (fin) begin
                  rd_phase = PH_IDLE;
                  rd_ticks = '0;
               end
            end
         endcase
      end
      r.drive_low          = (rd_phase == PH_START_LOW);
      r.busy_res           = (rd_phase != PH_IDLE);
      r.done_res           = fin;
      r.status             = fin ? st : STATUS_OK;
      r.humidity_tenths    = rd_hum;
      r.temperature_tenths = rd_temp;
   endtask

   // Receiver stalls
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic void check_field(string label, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", label, want, got);
         fail_count++;
      end
   endfunction

   // Result word checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reader_outputs_due.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_data);
            fail_count++;
         end else begin
            want = reader_outputs_due.pop_front();
            check_field("drive_low", want.drive_low, rsp_data.drive_low);
            check_field("busy_res", want.busy_res, rsp_data.busy_res);
            check_field("done_res", want.done_res, rsp_data.done_res);
            check_field("status", want.status, rsp_data.status);
            check_field("humidity_tenths", want.humidity_tenths, rsp_data.humidity_tenths);
            check_field("temperature_tenths", want.temperature_tenths,
                        rsp_data.temperature_tenths);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      int unsigned cycle_count;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Send one word; the model steps at the edge that accepts it
   task automatic send_word(input logic kind, input logic line);
      req_type w;
      rsp_type due;
      w.kind       = kind;
      w.line_level = line;
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      // count only words that the sequencer acts on
      if ((kind == KIND_START) == (rd_phase == PH_IDLE)) ticks_sent++;
      step_reader(w, due);
      reader_outputs_due.push_back(due);
   endtask

   task automatic send_run(input logic level, input int n);
      repeat (n) send_word(KIND_TICK, level);
   endtask

   // Hold off input until every expected result word is in
   task automatic settle();
      req_valid <= 1'b0;
      while (reader_outputs_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      case (idx)
         CSR_SENSOR_TYPE:      reg_set.sensor_type      = value[0];
         CSR_START_LOW_SHORT:  reg_set.start_low_short  = value;
         CSR_START_LOW_LONG:   reg_set.start_low_long   = value;
         CSR_RESPONSE_TIMEOUT: reg_set.response_timeout = value[9:0];
         CSR_BIT_LOW_TIMEOUT:  reg_set.bit_low_timeout  = value[9:0];
         CSR_BIT_HIGH_TIMEOUT: reg_set.bit_high_timeout = value[9:0];
         CSR_ONE_THRESHOLD:    reg_set.one_threshold    = value[9:0];
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_config(input logic sensor, input logic [15:0] short_len,
                              input logic [15:0] long_len, input logic [9:0] resp_lim,
                              input logic [9:0] low_lim, input logic [9:0] high_lim,
                              input logic [9:0] thr);
      settle();
      write_reg(CSR_SENSOR_TYPE, {15'd0, sensor});
      write_reg(CSR_START_LOW_SHORT, short_len);
      write_reg(CSR_START_LOW_LONG, long_len);
      write_reg(CSR_RESPONSE_TIMEOUT, {6'd0, resp_lim});
      write_reg(CSR_BIT_LOW_TIMEOUT, {6'd0, low_lim});
      write_reg(CSR_BIT_HIGH_TIMEOUT, {6'd0, high_lim});
      write_reg(CSR_ONE_THRESHOLD, {6'd0, thr});
   endtask

   function automatic logic [39:0] frame_of(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3);
      logic [7:0] sum8;
      sum8 = b0 + b1 + b2 + b3;
      return {b0, b1, b2, b3, sum8};
   endfunction

   // Level time that stays under a wait limit (limit of at least 2)
   function automatic int span(input int lim);
      return $urandom_range(1, (lim > 6) ? 5 : lim - 1);
   endfunction

   // High time of one data bit around the threshold
   function automatic int high_span(input logic one);
      int thr;
      int top;
      thr = reg_set.one_threshold;
      top = reg_set.bit_high_timeout - 1;
      if (one) return $urandom_range(thr + 1, (top > thr + 5) ? thr + 5 : top);
      return $urandom_range(1, (thr > 5) ? 5 : thr);
   endfunction

   // One read: start, pulse and release, response, data bits. A cut below 43
   // breaks the sequence at that segment with noise and a held level.
   task automatic run_read(input logic [39:0] frame, input int cut);
      logic hold;
      send_word(KIND_START, $urandom_range(1));
      send_word(KIND_START, $urandom_range(1));
      while (rd_phase == PH_START_LOW || rd_phase == PH_RELEASE)
         send_word(KIND_TICK, $urandom_range(1));
      for (int seg = 0; seg < 43 && seg != cut; seg++) begin
         case (seg)
            0, 2: send_run(1'b1, span(reg_set.response_timeout));
            1:    send_run(1'b0, span(reg_set.response_timeout));
            default: begin
               send_run(1'b0, span(reg_set.bit_low_timeout));
               send_run(1'b1, high_span(frame[42 - seg]));
            end
         endcase
      end
      if (cut >= 43) begin
         // closing low ends the last bit
         send_word(KIND_TICK, 1'b0);
      end else begin
         repeat ($urandom_range(0, 6))
            send_word((rd_phase != PH_IDLE && $urandom_range(3) == 0) ? KIND_START : KIND_TICK,
                      $urandom_range(1));
      end
      hold = $urandom_range(1);
      while (rd_phase != PH_IDLE) send_word(KIND_TICK, hold);
   endtask

   // ---- tests ----

   task automatic test_idle_ticks();
      send_word(KIND_TICK, 1'b0);
      send_word(KIND_TICK, 1'b1);
   endtask

   task automatic test_newer_sensor();
      load_config(SENSOR_NEW, 16'd3, 16'd7, 10'd8, 10'd4, 10'd8, 10'd3);
      run_read(frame_of(8'h02, 8'h8C, 8'h80, 8'h65), 43);   // negative temperature
      run_read(frame_of(8'h01, 8'h00, 8'h80, 8'h00), 43);   // negative zero
      run_read(frame_of(8'hFF, 8'hFF, 8'h7F, 8'hFF), 43);
   endtask

   task automatic test_older_sensor();
      // zero long pulse behaves as one tick
      load_config(SENSOR_OLD, 16'd9, 16'd0, 10'd6, 10'd3, 10'd6, 10'd2);
      run_read(frame_of(8'hFF, 8'h00, 8'hFF, 8'h00), 43);
      run_read(frame_of(8'h2D, 8'h05, 8'h19, 8'h07), 43);
   endtask

   task automatic test_checksum_error();
      load_config(SENSOR_NEW, 16'd2, 16'd2, 10'd5, 10'd3, 10'd6, 10'd2);
      run_read(frame_of(8'h37, 8'h21, 8'h00, 8'hF2) ^ 40'h01, 43);
   endtask

   task automatic test_timeouts();
      int cuts[6] = '{0, 1, 2, 3, 22, 42};
      // zero limits fail on the first counted tick
      load_config(SENSOR_NEW, 16'd0, 16'd0, 10'd0, 10'd3, 10'd5, 10'd2);
      run_read(40'h0, 0);
      load_config(SENSOR_NEW, 16'd2, 16'd2, 10'd4, 10'd0, 10'd0, 10'd0);
      run_read(40'h0, 3);
      load_config(SENSOR_NEW, 16'd2, 16'd2, 10'd5, 10'd3, 10'd5, 10'd2);
      foreach (cuts[i]) run_read({$urandom, 8'h00}, cuts[i]);
   endtask

   task automatic test_threshold_extremes();
      load_config(SENSOR_NEW, 16'd1, 16'd1, 10'd1023, 10'd1023, 10'd1023, 10'd0);
      run_read(40'hFF_FFFF_FFFF, 43);
      load_config(SENSOR_OLD, 16'd1, 16'd1, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
      run_read(40'h0, 43);
   endtask

   task automatic test_long_timeouts();
      load_config(SENSOR_NEW, 16'd1, 16'd1, 10'd1023, 10'd1023, 10'd1023, 10'd4);
      run_read(40'h0, 0);
      run_read(40'h0, 20);
   endtask

   task automatic test_random_reads(input int unsigned quota);
      int unsigned stop_at;
      logic [7:0]  b0, b1, b2, b3;
      logic [39:0] frame;
      logic [9:0]  thr;
      int          pick;
      stop_at = ticks_sent + quota;
      while (ticks_sent < stop_at) begin
         thr = $urandom_range(1, 4);
         load_config($urandom_range(1), $urandom_range(0, 6), $urandom_range(0, 6),
                     $urandom_range(2, 8), $urandom_range(2, 5),
                     thr + $urandom_range(2, 5), thr);
         repeat ($urandom_range(1, 3)) begin
            {b0, b1, b2, b3} = $urandom;
            if ($urandom_range(9) == 0) {b2, b3} = 16'h8000;
            frame = frame_of(b0, b1, b2, b3);
            pick  = $urandom_range(99);
            if (pick < 15) frame[7:0] = $urandom;
            if ($urandom_range(29) == 0) settle();
            repeat ($urandom_range(0, 2)) send_word(KIND_TICK, $urandom_range(1));
            run_read(frame, (pick >= 75) ? $urandom_range(0, 42) : 43);
         end
      end
   endtask

   task automatic test_long_start();
      load_config(SENSOR_NEW, 16'd300, 16'd1, 10'd3, 10'd3, 10'd5, 10'd2);
      run_read(frame_of(8'h12, 8'h34, 8'h01, 8'h56), 43);
      load_config(SENSOR_OLD, 16'd1, 16'd300, 10'd3, 10'd3, 10'd5, 10'd2);
      run_read(40'h0, 0);
   endtask

   initial begin
      reg_set = '{sensor_type: SENSOR_NEW, start_low_short: 16'd1500,
                  start_low_long: 16'd18000, response_timeout: 10'd200,
                  bit_low_timeout: 10'd100, bit_high_timeout: 10'd120,
                  one_threshold: 10'd40};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct   = 9;
      recv_stall_pct = 55;
      test_idle_ticks();
      test_newer_sensor();
      test_older_sensor();
      test_checksum_error();
      test_timeouts();
      test_threshold_extremes();
      test_long_timeouts();
      test_random_reads(520);

      send_gap_pct   = 55;
      recv_stall_pct = 9;
      test_random_reads(520);

      send_gap_pct   = 0;
      recv_stall_pct = 0;
      test_random_reads(520);
      test_long_start();

      settle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && reader_outputs_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
